### rtl/rrts_pkg.sv
// Types and codes shared by the round-robin thread scheduler modules.
package rrts_pkg;

  localparam logic [23:0] QLEN_RESET = 24'd1000;

  typedef enum logic [2:0] {
    FN_TICK   = 3'd0,
    FN_SPAWN  = 3'd1,
    FN_TERM   = 3'd2,
    FN_BLOCK  = 3'd3,
    FN_RESUME = 3'd4,
    FN_SLEEP  = 3'd5,
    FN_QUERY  = 3'd6,
    FN_UNUSED = 3'd7
  } func_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_RANGE   = 3'd1,
    ST_UNUSED  = 3'd2,
    ST_FULL    = 3'd3,
    ST_BLOCKED = 3'd4,
    ST_SLEEP   = 3'd5,
    ST_THREAD0 = 3'd6,
    ST_RESET   = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    MD_READY   = 2'd0,
    MD_BLOCKED = 2'd1,
    MD_RUNNING = 2'd2
  } mode_t;

  typedef struct packed {
    func_t       func;
    logic [7:0]  tid;
    logic [15:0] sleep_quantums;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] value;
    logic [7:0]  running_tid;
    logic [31:0] total_quanta;
  } rsp_t;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] sleep;
    logic [31:0] run;
  } rec_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_DECIDE, S_SP_SCAN, S_SP_WR, S_RM_RD, S_RM_CMP, S_SH_RD,
    S_SH_WR, S_BLK_WR, S_RES_WR, S_QRY, S_FREE, S_SW_RD, S_SW_UPD, S_SW_OLD_RD,
    S_SW_OLD_WR, S_SW_POP_RD, S_SW_POP, S_SW_NXT_WR, S_SW_FIN, S_RST, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_IDLE, OP_NONE, OP_CHECK, OP_DECIDE, OP_SP_SCAN, OP_SP_WR, OP_RM_RD,
    OP_RM_CMP, OP_SH_RD, OP_RM_DEC, OP_SH_WR, OP_BLK_WR, OP_RES_WR, OP_QRY,
    OP_FREE, OP_SW_RD, OP_SW_UPD, OP_SW_OLD_RD, OP_SW_OLD_WR, OP_SW_POP_RD,
    OP_SW_POP, OP_SW_NXT_WR, OP_SW_FIN, OP_RST, OP_DONE
  } op_t;

  typedef struct packed {
    op_t     op;
    logic    set_status;
    status_t code;
  } cmd_t;

  typedef struct packed {
    logic  req_fire;
    logic  rsp_busy;
    func_t func;
    logic  tid_oor;
    logic  tid_unused;
    logic  tid_zero;
    logic  tid_is_cur;
    logic  cur_zero;
    logic  nsl_zero;
    logic  live_full;
    logic  tick_expire;
    logic  rd_blocked;
    logic  rd_ready_idle;
    logic  idx_last;
    logic  slot_free;
    logic  rm_done;
    logic  rm_match;
    logic  sh_end;
    logic  fifo_empty;
  } sts_t;

endpackage

### rtl/rrts_ctrl.sv
// Sequencing state machine of the thread scheduler.
module rrts_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  rrts_pkg::sts_t sts,
  output rrts_pkg::cmd_t cmd
);

  rrts_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rrts_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      rrts_pkg::S_IDLE: begin
        if (sts.req_fire) state_next = rrts_pkg::S_CHECK;
      end
      rrts_pkg::S_CHECK: begin
        if ((sts.func inside {rrts_pkg::FN_TERM, rrts_pkg::FN_BLOCK, rrts_pkg::FN_RESUME,
                              rrts_pkg::FN_QUERY}) && (sts.tid_oor || sts.tid_unused))
          state_next = rrts_pkg::S_DONE;
        else
          state_next = rrts_pkg::S_DECIDE;
      end
      rrts_pkg::S_DECIDE: begin
        case (sts.func)
          rrts_pkg::FN_TICK:
            state_next = sts.tick_expire ? rrts_pkg::S_SW_RD : rrts_pkg::S_DONE;
          rrts_pkg::FN_SPAWN:
            state_next = sts.live_full ? rrts_pkg::S_DONE : rrts_pkg::S_SP_SCAN;
          rrts_pkg::FN_TERM: begin
            if (sts.tid_zero) state_next = rrts_pkg::S_RST;
            else if (sts.tid_is_cur) state_next = rrts_pkg::S_SW_RD;
            else if (sts.rd_ready_idle) state_next = rrts_pkg::S_RM_RD;
            else state_next = rrts_pkg::S_FREE;
          end
          rrts_pkg::FN_BLOCK: begin
            if (sts.tid_zero || sts.rd_blocked) state_next = rrts_pkg::S_DONE;
            else if (sts.tid_is_cur) state_next = rrts_pkg::S_BLK_WR;
            else if (sts.rd_ready_idle) state_next = rrts_pkg::S_RM_RD;
            else state_next = rrts_pkg::S_BLK_WR;
          end
          rrts_pkg::FN_RESUME:
            state_next = sts.rd_blocked ? rrts_pkg::S_RES_WR : rrts_pkg::S_DONE;
          rrts_pkg::FN_SLEEP:
            state_next = (sts.nsl_zero || sts.cur_zero) ? rrts_pkg::S_DONE
                                                        : rrts_pkg::S_SW_RD;
          rrts_pkg::FN_QUERY: state_next = rrts_pkg::S_QRY;
          default:            state_next = rrts_pkg::S_DONE;
        endcase
      end
      rrts_pkg::S_SP_SCAN: begin
        if (sts.slot_free) state_next = rrts_pkg::S_SP_WR;
      end
      rrts_pkg::S_SP_WR: state_next = rrts_pkg::S_DONE;
      rrts_pkg::S_RM_RD: begin
        if (sts.rm_done)
          state_next = (sts.func == rrts_pkg::FN_TERM) ? rrts_pkg::S_FREE : rrts_pkg::S_BLK_WR;
        else
          state_next = rrts_pkg::S_RM_CMP;
      end
      rrts_pkg::S_RM_CMP:
        state_next = sts.rm_match ? rrts_pkg::S_SH_RD : rrts_pkg::S_RM_RD;
      rrts_pkg::S_SH_RD: begin
        if (sts.sh_end)
          state_next = (sts.func == rrts_pkg::FN_TERM) ? rrts_pkg::S_FREE : rrts_pkg::S_BLK_WR;
        else
          state_next = rrts_pkg::S_SH_WR;
      end
      rrts_pkg::S_SH_WR: state_next = rrts_pkg::S_SH_RD;
      rrts_pkg::S_BLK_WR:
        state_next = sts.tid_is_cur ? rrts_pkg::S_SW_RD : rrts_pkg::S_DONE;
      rrts_pkg::S_RES_WR: state_next = rrts_pkg::S_DONE;
      rrts_pkg::S_QRY:    state_next = rrts_pkg::S_DONE;
      rrts_pkg::S_FREE:   state_next = rrts_pkg::S_DONE;
      rrts_pkg::S_RST:    state_next = rrts_pkg::S_DONE;
      rrts_pkg::S_SW_RD:  state_next = rrts_pkg::S_SW_UPD;
      rrts_pkg::S_SW_UPD:
        state_next = sts.idx_last ? rrts_pkg::S_SW_OLD_RD : rrts_pkg::S_SW_RD;
      rrts_pkg::S_SW_OLD_RD: state_next = rrts_pkg::S_SW_OLD_WR;
      rrts_pkg::S_SW_OLD_WR: state_next = rrts_pkg::S_SW_POP_RD;
      rrts_pkg::S_SW_POP_RD:
        state_next = sts.fifo_empty ? rrts_pkg::S_SW_FIN : rrts_pkg::S_SW_POP;
      rrts_pkg::S_SW_POP:    state_next = rrts_pkg::S_SW_NXT_WR;
      rrts_pkg::S_SW_NXT_WR: state_next = rrts_pkg::S_SW_FIN;
      rrts_pkg::S_SW_FIN:
        state_next = (sts.func == rrts_pkg::FN_TERM) ? rrts_pkg::S_FREE : rrts_pkg::S_DONE;
      rrts_pkg::S_DONE: begin
        if (!sts.rsp_busy) state_next = rrts_pkg::S_IDLE;
      end
      default: state_next = rrts_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op         = rrts_pkg::OP_NONE;
    cmd.set_status = 1'b0;
    cmd.code       = rrts_pkg::ST_OK;
    case (state)
      rrts_pkg::S_IDLE: cmd.op = rrts_pkg::OP_IDLE;
      rrts_pkg::S_CHECK: begin
        cmd.op = rrts_pkg::OP_CHECK;
        if ((sts.func inside {rrts_pkg::FN_TERM, rrts_pkg::FN_BLOCK, rrts_pkg::FN_RESUME,
                              rrts_pkg::FN_QUERY}) && (sts.tid_oor || sts.tid_unused)) begin
          cmd.set_status = 1'b1;
          cmd.code       = sts.tid_oor ? rrts_pkg::ST_RANGE : rrts_pkg::ST_UNUSED;
        end
      end
      rrts_pkg::S_DECIDE: begin
        cmd.op = rrts_pkg::OP_DECIDE;
        case (sts.func)
          rrts_pkg::FN_SPAWN: begin
            cmd.set_status = sts.live_full;
            cmd.code       = rrts_pkg::ST_FULL;
          end
          rrts_pkg::FN_BLOCK: begin
            cmd.set_status = sts.tid_zero || sts.rd_blocked;
            cmd.code       = sts.tid_zero ? rrts_pkg::ST_THREAD0 : rrts_pkg::ST_BLOCKED;
          end
          rrts_pkg::FN_SLEEP: begin
            cmd.set_status = sts.nsl_zero || sts.cur_zero;
            cmd.code       = sts.nsl_zero ? rrts_pkg::ST_SLEEP : rrts_pkg::ST_THREAD0;
          end
          default: cmd.set_status = 1'b0;
        endcase
      end
      rrts_pkg::S_SP_SCAN: cmd.op = rrts_pkg::OP_SP_SCAN;
      rrts_pkg::S_SP_WR:   cmd.op = rrts_pkg::OP_SP_WR;
      rrts_pkg::S_RM_RD:   cmd.op = sts.rm_done ? rrts_pkg::OP_NONE : rrts_pkg::OP_RM_RD;
      rrts_pkg::S_RM_CMP:  cmd.op = rrts_pkg::OP_RM_CMP;
      rrts_pkg::S_SH_RD:   cmd.op = sts.sh_end ? rrts_pkg::OP_RM_DEC : rrts_pkg::OP_SH_RD;
      rrts_pkg::S_SH_WR:   cmd.op = rrts_pkg::OP_SH_WR;
      rrts_pkg::S_BLK_WR:  cmd.op = rrts_pkg::OP_BLK_WR;
      rrts_pkg::S_RES_WR:  cmd.op = rrts_pkg::OP_RES_WR;
      rrts_pkg::S_QRY:     cmd.op = rrts_pkg::OP_QRY;
      rrts_pkg::S_FREE:    cmd.op = rrts_pkg::OP_FREE;
      rrts_pkg::S_RST: begin
        cmd.op         = rrts_pkg::OP_RST;
        cmd.set_status = 1'b1;
        cmd.code       = rrts_pkg::ST_RESET;
      end
      rrts_pkg::S_SW_RD:     cmd.op = rrts_pkg::OP_SW_RD;
      rrts_pkg::S_SW_UPD:    cmd.op = rrts_pkg::OP_SW_UPD;
      rrts_pkg::S_SW_OLD_RD: cmd.op = rrts_pkg::OP_SW_OLD_RD;
      rrts_pkg::S_SW_OLD_WR: cmd.op = rrts_pkg::OP_SW_OLD_WR;
      rrts_pkg::S_SW_POP_RD:
        cmd.op = sts.fifo_empty ? rrts_pkg::OP_NONE : rrts_pkg::OP_SW_POP_RD;
      rrts_pkg::S_SW_POP:    cmd.op = rrts_pkg::OP_SW_POP;
      rrts_pkg::S_SW_NXT_WR: cmd.op = rrts_pkg::OP_SW_NXT_WR;
      rrts_pkg::S_SW_FIN:    cmd.op = rrts_pkg::OP_SW_FIN;
      rrts_pkg::S_DONE:      cmd.op = rrts_pkg::OP_DONE;
      default:               cmd.op = rrts_pkg::OP_NONE;
    endcase
  end

endmodule

### rtl/rrts_dp.sv
// Datapath of the thread scheduler: thread table, ready queue, counters, result register.
module rrts_dp #(
  parameter int MAX_THREADS = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  rrts_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output rrts_pkg::rsp_t rsp,
  input  logic           cfg_valid,
  input  logic [23:0]    cfg_data,
  input  rrts_pkg::cmd_t cmd,
  output rrts_pkg::sts_t sts
);

  localparam int IDW = $clog2(MAX_THREADS);
  localparam logic [IDW:0] NUM = (IDW + 1)'(MAX_THREADS);
  localparam rrts_pkg::rec_t FRESH = '{mode: rrts_pkg::MD_READY, sleep: 16'd0, run: 32'd0};
  localparam rrts_pkg::rec_t REC0  = '{mode: rrts_pkg::MD_RUNNING, sleep: 16'd0, run: 32'd1};

  function automatic logic [IDW-1:0] wrap(input logic [IDW:0] s);
    return (s >= NUM) ? IDW'(s - NUM) : IDW'(s);
  endfunction

  logic [23:0]            qlen;
  rrts_pkg::req_t         req_q;
  rrts_pkg::status_t      status_q;
  logic [31:0]            value_q;
  logic [MAX_THREADS-1:0] in_use;
  logic [MAX_THREADS-1:0] vld;
  rrts_pkg::rec_t         thr_mem [MAX_THREADS];
  logic [IDW-1:0]         fifo_mem [MAX_THREADS];
  logic [IDW-1:0]         head;
  logic [IDW:0]           count;
  logic [IDW-1:0]         cur;
  logic [31:0]            total;
  logic [23:0]            ticks;
  logic [IDW:0]           live;
  logic [IDW:0]           idx;
  rrts_pkg::rec_t         trec;
  rrts_pkg::rec_t         thr_q;
  logic                   thr_vld_q;
  logic                   thr_zero_q;
  logic [IDW-1:0]         fifo_q;
  rrts_pkg::rsp_t         rsp_q;
  logic                   rsp_valid_q;

  logic [IDW-1:0]  tid_i;
  logic [IDW-1:0]  idx_i;
  rrts_pkg::rec_t  rd_rec;
  logic [23:0]     ticks_inc;
  logic            req_fire;
  logic            rsp_busy;
  logic            thr_we;
  logic [IDW-1:0]  thr_waddr;
  rrts_pkg::rec_t  thr_wdata;
  logic [IDW-1:0]  thr_raddr;
  logic            push_en;
  logic [IDW-1:0]  push_id;
  logic            push_ok;
  logic            shift_we;
  logic            fifo_we;
  logic [IDW-1:0]  fifo_waddr;
  logic [IDW-1:0]  fifo_wdata;
  logic [IDW-1:0]  fifo_raddr;

  assign tid_i     = req_q.tid[IDW-1:0];
  assign idx_i     = idx[IDW-1:0];
  assign rd_rec    = thr_vld_q ? thr_q : (thr_zero_q ? REC0 : FRESH);
  assign ticks_inc = (ticks == 24'hFFFFFF) ? ticks : ticks + 24'd1;
  assign req_stall = (cmd.op != rrts_pkg::OP_IDLE);
  assign req_fire  = req_valid && !req_stall;
  assign rsp_busy  = rsp_valid_q && rsp_stall;
  assign rsp_valid = rsp_valid_q;
  assign rsp       = rsp_q;
  assign push_ok   = push_en && (count != NUM);

  always_comb begin
    sts.req_fire      = req_fire;
    sts.rsp_busy      = rsp_busy;
    sts.func          = req_q.func;
    sts.tid_oor       = {1'b0, req_q.tid} >= 9'(MAX_THREADS);
    sts.tid_unused    = !in_use[tid_i];
    sts.tid_zero      = (req_q.tid == 8'd0);
    sts.tid_is_cur    = !sts.tid_oor && (tid_i == cur);
    sts.cur_zero      = (cur == '0);
    sts.nsl_zero      = (req_q.sleep_quantums == 16'd0);
    sts.live_full     = (live == NUM);
    sts.tick_expire   = (ticks_inc >= qlen);
    sts.rd_blocked    = (rd_rec.mode == rrts_pkg::MD_BLOCKED);
    sts.rd_ready_idle = (rd_rec.mode == rrts_pkg::MD_READY) && (rd_rec.sleep == 16'd0);
    sts.idx_last      = (idx == NUM - (IDW + 1)'(1));
    sts.slot_free     = !in_use[idx_i];
    sts.rm_done       = (idx >= count);
    sts.rm_match      = (fifo_q == tid_i);
    sts.sh_end        = ((idx + (IDW + 1)'(1)) >= count);
    sts.fifo_empty    = (count == '0);
  end

  always_comb begin
    thr_we     = 1'b0;
    thr_waddr  = cur;
    thr_wdata  = rd_rec;
    thr_raddr  = cur;
    push_en    = 1'b0;
    push_id    = cur;
    shift_we   = 1'b0;
    fifo_raddr = head;
    case (cmd.op)
      rrts_pkg::OP_CHECK: thr_raddr = tid_i;
      rrts_pkg::OP_SP_WR: begin
        thr_we    = 1'b1;
        thr_waddr = idx_i;
        thr_wdata = FRESH;
        push_en   = 1'b1;
        push_id   = idx_i;
      end
      rrts_pkg::OP_RM_RD: fifo_raddr = wrap((IDW + 1)'(head) + idx);
      rrts_pkg::OP_SH_RD: fifo_raddr = wrap((IDW + 1)'(head) + idx + (IDW + 1)'(1));
      rrts_pkg::OP_SH_WR: shift_we = 1'b1;
      rrts_pkg::OP_BLK_WR: begin
        thr_we         = 1'b1;
        thr_waddr      = tid_i;
        thr_wdata      = trec;
        thr_wdata.mode = rrts_pkg::MD_BLOCKED;
      end
      rrts_pkg::OP_RES_WR: begin
        thr_we         = 1'b1;
        thr_waddr      = tid_i;
        thr_wdata      = trec;
        thr_wdata.mode = rrts_pkg::MD_READY;
        push_en        = (trec.sleep == 16'd0);
        push_id        = tid_i;
      end
      rrts_pkg::OP_FREE: begin
        thr_we    = 1'b1;
        thr_waddr = tid_i;
        thr_wdata = FRESH;
      end
      rrts_pkg::OP_SW_RD: thr_raddr = idx_i;
      rrts_pkg::OP_SW_UPD: begin
        thr_waddr       = idx_i;
        thr_wdata.sleep = rd_rec.sleep - 16'd1;
        thr_we          = (rd_rec.sleep != 16'd0);
        push_en         = (rd_rec.sleep == 16'd1) && in_use[idx_i] &&
                          (rd_rec.mode == rrts_pkg::MD_READY);
        push_id         = idx_i;
      end
      rrts_pkg::OP_SW_OLD_WR: begin
        if (req_q.func == rrts_pkg::FN_SLEEP) begin
          thr_we          = 1'b1;
          thr_wdata.sleep = req_q.sleep_quantums;
          thr_wdata.mode  = rrts_pkg::MD_READY;
        end
        if (req_q.func == rrts_pkg::FN_TICK) begin
          thr_we         = 1'b1;
          thr_wdata.mode = rrts_pkg::MD_READY;
          push_en        = 1'b1;
        end
      end
      rrts_pkg::OP_SW_POP: thr_raddr = fifo_q;
      rrts_pkg::OP_SW_NXT_WR: begin
        thr_we         = 1'b1;
        thr_wdata.mode = rrts_pkg::MD_RUNNING;
        if (rd_rec.run != 32'hFFFFFFFF) thr_wdata.run = rd_rec.run + 32'd1;
      end
      default: thr_we = 1'b0;
    endcase
  end

  assign fifo_we    = push_ok || shift_we;
  assign fifo_waddr = shift_we ? wrap((IDW + 1)'(head) + idx) : wrap((IDW + 1)'(head) + count);
  assign fifo_wdata = shift_we ? fifo_q : push_id;

  always_ff @(posedge clk) begin
    if (thr_we) thr_mem[thr_waddr] <= thr_wdata;
    thr_q      <= thr_mem[thr_raddr];
    thr_vld_q  <= vld[thr_raddr];
    thr_zero_q <= (thr_raddr == '0);
    if (fifo_we) fifo_mem[fifo_waddr] <= fifo_wdata;
    fifo_q <= fifo_mem[fifo_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qlen <= rrts_pkg::QLEN_RESET;
    end else if (cfg_valid) begin
      qlen <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.op == rrts_pkg::OP_RST) begin
      in_use <= MAX_THREADS'(1);
      vld    <= '0;
      head   <= '0;
      count  <= '0;
      cur    <= '0;
      total  <= 32'd1;
      ticks  <= '0;
      live   <= (IDW + 1)'(1);
      idx    <= '0;
    end else begin
      if (thr_we) vld[thr_waddr] <= 1'b1;
      if (push_ok) count <= count + (IDW + 1)'(1);
      case (cmd.op)
        rrts_pkg::OP_DECIDE: begin
          idx <= '0;
          if (req_q.func == rrts_pkg::FN_TICK) ticks <= ticks_inc;
        end
        rrts_pkg::OP_SP_SCAN: begin
          if (in_use[idx_i]) idx <= idx + (IDW + 1)'(1);
        end
        rrts_pkg::OP_SP_WR: begin
          in_use[idx_i] <= 1'b1;
          live          <= live + (IDW + 1)'(1);
        end
        rrts_pkg::OP_RM_CMP: begin
          if (fifo_q != tid_i) idx <= idx + (IDW + 1)'(1);
        end
        rrts_pkg::OP_SH_WR:  idx   <= idx + (IDW + 1)'(1);
        rrts_pkg::OP_RM_DEC: count <= count - (IDW + 1)'(1);
        rrts_pkg::OP_FREE: begin
          in_use[tid_i] <= 1'b0;
          if (live != '0) live <= live - (IDW + 1)'(1);
        end
        rrts_pkg::OP_SW_UPD: idx <= idx + (IDW + 1)'(1);
        rrts_pkg::OP_SW_POP: begin
          cur   <= fifo_q;
          head  <= wrap((IDW + 1)'(head) + (IDW + 1)'(1));
          count <= count - (IDW + 1)'(1);
        end
        rrts_pkg::OP_SW_FIN: begin
          if (total != 32'hFFFFFFFF) total <= total + 32'd1;
          ticks <= '0;
        end
        default: idx <= idx;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd.op == rrts_pkg::OP_DONE && !rsp_busy) begin
      rsp_valid_q <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      req_q    <= req;
      value_q  <= 32'd0;
      status_q <= rrts_pkg::ST_OK;
    end
    if (cmd.set_status) status_q <= cmd.code;
    if (cmd.op == rrts_pkg::OP_DECIDE) trec <= rd_rec;
    if (cmd.op == rrts_pkg::OP_SP_WR) value_q <= 32'(idx_i);
    if (cmd.op == rrts_pkg::OP_QRY) value_q <= trec.run;
    if (cmd.op == rrts_pkg::OP_DONE && !rsp_busy) begin
      rsp_q <= '{status: status_q, value: value_q, running_tid: 8'(cur),
                 total_quanta: total};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= NUM)
    else $error("ready queue count above capacity");
  a_live_match: assert property (@(posedge clk) disable iff (rst)
    $countones(in_use) == int'(live))
    else $error("live thread count differs from used slots");
  a_thread0_used: assert property (@(posedge clk) disable iff (rst) in_use[0])
    else $error("thread 0 slot released");
  a_head_range: assert property (@(posedge clk) disable iff (rst)
    (IDW + 1)'(head) < NUM)
    else $error("queue head out of range");

endmodule

### rtl/round_robin_thread_scheduler.sv
// Top level of the round-robin thread scheduler.
//
// Requests arrive on req (req_valid/req_stall) and are taken when req_valid is high and
// req_stall is low; each request gives exactly one response on rsp (rsp_valid/rsp_stall).
// cfg_valid/cfg_ready writes quantum_length; cfg_ready is always high.
// One request at a time. A spawn scans the thread table for a free slot; a thread switch walks
// every sleep counter through the thread table, one thread after another. Removing a thread from
// the ready queue searches and shifts the queue memory entry by entry.
// The response sits in an output register; a new request is taken while it waits, and the
// next response holds until rsp_stall drops.
// Reset leaves thread 0 running, one quantum counted, quantum_length 1000; no clearing pass.
// Terminating thread 0 returns all thread state to that condition with status ST_RESET.
module round_robin_thread_scheduler #(
  parameter int MAX_THREADS = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  rrts_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output rrts_pkg::rsp_t rsp,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [23:0]    cfg_data
);

  rrts_pkg::cmd_t cmd;
  rrts_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  rrts_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  rrts_dp #(
    .MAX_THREADS (MAX_THREADS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
